// ===== hw/rtl/sts_pkg.sv =====
// Shared types, token codes, character codes and keyword table of the token scanner.
`default_nettype none

package sts_pkg;

    // Scan modes held between bytes.
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_OP,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_STRING
    } t_mode;

    typedef logic [5:0] t_kind;

    // Input word commands.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Token kinds.
    localparam t_kind K_LEFT_PAREN    = 6'd0;
    localparam t_kind K_RIGHT_PAREN   = 6'd1;
    localparam t_kind K_LEFT_BRACE    = 6'd2;
    localparam t_kind K_RIGHT_BRACE   = 6'd3;
    localparam t_kind K_COMMA         = 6'd4;
    localparam t_kind K_DOT           = 6'd5;
    localparam t_kind K_MINUS         = 6'd6;
    localparam t_kind K_PLUS          = 6'd7;
    localparam t_kind K_SEMICOLON     = 6'd8;
    localparam t_kind K_SLASH         = 6'd9;
    localparam t_kind K_STAR          = 6'd10;
    localparam t_kind K_BANG          = 6'd11;
    localparam t_kind K_EQUAL         = 6'd13;
    localparam t_kind K_GREATER       = 6'd15;
    localparam t_kind K_LESS          = 6'd17;
    localparam t_kind K_IDENT         = 6'd19;
    localparam t_kind K_STRING        = 6'd20;
    localparam t_kind K_NUMBER        = 6'd21;
    localparam t_kind K_KEYWORD0      = 6'd22;
    localparam t_kind K_EOF           = 6'd38;
    localparam t_kind K_UNEXPECTED    = 6'd39;
    localparam t_kind K_UNTERMINATED  = 6'd40;

    // Character codes.
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    localparam int KW_COUNT = 16;
    localparam int KW_BITS  = 48;

    // Push request into the result queue: the second word only comes with the first.
    typedef struct packed {
        logic push0;
        logic push1;
    } t_push;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == CH_UNDER);
    endfunction

    // Kind of a one- or two-character comparison operator.
    function automatic t_kind op_kind(input logic [7:0] ch, input logic two);
        t_kind base;
        if (ch == CH_BANG) begin
            base = K_BANG;
        end else if (ch == CH_EQUAL) begin
            base = K_EQUAL;
        end else if (ch == CH_GREATER) begin
            base = K_GREATER;
        end else begin
            base = K_LESS;
        end
        return base + {5'd0, two};
    endfunction

    // Reserved words, packed with the first character most significant.
    function automatic logic [KW_BITS-1:0] kw_text(input logic [3:0] idx);
        logic [KW_BITS-1:0] t;
        unique case (idx)
            4'd0:  t = "and";
            4'd1:  t = "class";
            4'd2:  t = "else";
            4'd3:  t = "false";
            4'd4:  t = "fun";
            4'd5:  t = "for";
            4'd6:  t = "if";
            4'd7:  t = "nil";
            4'd8:  t = "or";
            4'd9:  t = "print";
            4'd10: t = "return";
            4'd11: t = "super";
            4'd12: t = "this";
            4'd13: t = "true";
            4'd14: t = "var";
            default: t = "while";
        endcase
        return t;
    endfunction

    function automatic logic [2:0] kw_len(input logic [3:0] idx);
        logic [2:0] n;
        unique case (idx)
            4'd0, 4'd4, 4'd5, 4'd7, 4'd14:   n = 3'd3;
            4'd2, 4'd12, 4'd13:              n = 3'd4;
            4'd1, 4'd3, 4'd9, 4'd11, 4'd15: n = 3'd5;
            4'd10:                           n = 3'd6;
            default:                         n = 3'd2;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sts_out_fifo.sv =====
// Four-entry result queue that takes up to two words per cycle and gives one.
`default_nettype none

module sts_out_fifo #(
    parameter int WIDTH = 98
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  sts_pkg::t_push        i_push,
    input  wire  [WIDTH-1:0]      i_data0,
    input  wire  [WIDTH-1:0]      i_data1,
    output logic                  o_room2,
    output logic                  o_valid,
    input  wire                   i_ready,
    output logic [WIDTH-1:0]      o_data
);
    import sts_pkg::*;

    logic [WIDTH-1:0] r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [PTR_W-1:0] wr1;
    logic             pop;

    assign o_valid = (r_cnt != '0);
    assign o_room2 = (r_cnt <= CNT_W'(FIFO_DEPTH - 2));
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign wr1     = r_wr + 1'b1;

    always_comb begin
        n_wr  = r_wr + PTR_W'(i_push.push0) + PTR_W'(i_push.push1);
        n_rd  = r_rd + PTR_W'(pop);
        n_cnt = r_cnt + CNT_W'(i_push.push0) + CNT_W'(i_push.push1) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push.push1) begin
            r_mem[wr1] <= i_data1;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/source_token_scanner_core.sv =====
// Top level of the streaming source token scanner.
// A token's result word is written into the result queue when the byte (or end word)
// that completes it is accepted.
// One input word per cycle while the queue has room; results leave a four-entry queue
// at one word per cycle while the output is ready. A word that closes one token and emits
// another pushes two words. Input is held off while fewer than two queue entries are free.
// Reset: synchronous, active low; scan state returns to idle, line one, offset zero.
`default_nettype none

module source_token_scanner_core #(
    parameter int POS_BITS      = 24,
    parameter int LINE_BITS     = 20,
    parameter int KEYWORD_CHARS = 6
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire                    i_command,
    input  wire  [7:0]             i_source_byte,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output logic [5:0]             o_token_kind,
    output logic [LINE_BITS-1:0]   o_token_line,
    output logic [POS_BITS-1:0]    o_start_offset,
    output logic [POS_BITS-1:0]    o_end_offset,
    output logic                   o_last_of_run
);
    import sts_pkg::*;

    localparam int WORD_BITS = 8 * KEYWORD_CHARS;
    // The length counter must hold KEYWORD_CHARS + 1, which flags an over-long word.
    localparam int LEN_BITS  = $clog2(KEYWORD_CHARS + 2);

    typedef struct packed {
        t_kind                kind;
        logic [LINE_BITS-1:0] line;
        logic [POS_BITS-1:0]  start;
        logic [POS_BITS-1:0]  stop;
        logic                 last;
    } t_result;

    // Scanner state.
    t_mode                r_mode, n_mode;
    logic [7:0]           r_pend, n_pend;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic [POS_BITS-1:0]  r_pos, n_pos;
    logic [POS_BITS-1:0]  r_start, n_start;
    logic [WORD_BITS-1:0] r_word, n_word;
    logic [LEN_BITS-1:0]  r_len, n_len;

    logic                 accept;
    logic [7:0]           c;
    logic [POS_BITS-1:0]  pos_inc;
    logic [LINE_BITS-1:0] line_inc;

    // Decode of the byte as the first byte of a new token.
    logic                 f_put;
    t_kind                f_kind;
    t_mode                f_mode;
    logic                 f_nl;
    logic                 f_open;
    logic                 f_pend;
    logic                 f_ident;

    t_kind                word_kind;
    t_kind                open_kind;

    // Result word assembly.
    logic                 close_put;
    t_kind                close_kind;
    logic [POS_BITS-1:0]  close_end;
    logic                 second_put;
    t_kind                second_kind;
    logic [POS_BITS-1:0]  second_start;
    logic [POS_BITS-1:0]  second_end;
    logic                 use_fresh;

    t_result              res_close, res_second, data0, data1, out_word;
    t_push                push;
    logic                 room2;

    assign c        = i_source_byte;
    assign accept   = i_in_valid && o_in_ready;
    assign o_in_ready = room2;
    assign pos_inc  = (r_pos == '1) ? r_pos : r_pos + 1'b1;
    assign line_inc = (r_line == '1) ? r_line : r_line + 1'b1;

    // Keyword match: sixteen independent compares against the held word.
    always_comb begin
        word_kind = K_IDENT;
        if (r_len <= LEN_BITS'(KEYWORD_CHARS)) begin
            for (int i = 0; i < KW_COUNT; i++) begin
                if ((r_len == LEN_BITS'(kw_len(4'(i))))
                        && (r_word == WORD_BITS'(kw_text(4'(i))))) begin
                    word_kind = K_KEYWORD0 + 6'(i);
                end
            end
        end
    end

    // Kind of the open token when something ends it.
    always_comb begin
        unique case (r_mode)
            MODE_OP:     open_kind = op_kind(r_pend, 1'b0);
            MODE_SLASH:  open_kind = K_SLASH;
            MODE_NUMBER: open_kind = K_NUMBER;
            default:     open_kind = word_kind;
        endcase
    end

    // How a byte starts a fresh scan from idle.
    always_comb begin
        f_put   = 1'b0;
        f_kind  = K_UNEXPECTED;
        f_mode  = MODE_IDLE;
        f_nl    = 1'b0;
        f_open  = 1'b0;
        f_pend  = 1'b0;
        f_ident = 1'b0;
        unique case (c) inside
            CH_SPACE, CH_CR, CH_TAB: begin
            end
            CH_NL: f_nl = 1'b1;
            CH_LPAREN: begin
                f_put = 1'b1; f_kind = K_LEFT_PAREN;
            end
            CH_RPAREN: begin
                f_put = 1'b1; f_kind = K_RIGHT_PAREN;
            end
            CH_LBRACE: begin
                f_put = 1'b1; f_kind = K_LEFT_BRACE;
            end
            CH_RBRACE: begin
                f_put = 1'b1; f_kind = K_RIGHT_BRACE;
            end
            CH_COMMA: begin
                f_put = 1'b1; f_kind = K_COMMA;
            end
            CH_DOT: begin
                f_put = 1'b1; f_kind = K_DOT;
            end
            CH_MINUS: begin
                f_put = 1'b1; f_kind = K_MINUS;
            end
            CH_PLUS: begin
                f_put = 1'b1; f_kind = K_PLUS;
            end
            CH_SEMI: begin
                f_put = 1'b1; f_kind = K_SEMICOLON;
            end
            CH_STAR: begin
                f_put = 1'b1; f_kind = K_STAR;
            end
            CH_BANG, CH_EQUAL, CH_LESS, CH_GREATER: begin
                f_mode = MODE_OP; f_open = 1'b1; f_pend = 1'b1;
            end
            CH_SLASH: begin
                f_mode = MODE_SLASH; f_open = 1'b1;
            end
            CH_QUOTE: begin
                f_mode = MODE_STRING; f_open = 1'b1;
            end
            default: begin
                if (is_digit(c)) begin
                    f_mode = MODE_NUMBER; f_open = 1'b1;
                end else if (is_word(c)) begin
                    f_mode = MODE_IDENT; f_open = 1'b1; f_ident = 1'b1;
                end else begin
                    f_put = 1'b1; f_kind = K_UNEXPECTED;
                end
            end
        endcase
    end

    // Next state and the up to two result words of this input word.
    always_comb begin
        n_mode       = r_mode;
        n_pend       = r_pend;
        n_line       = r_line;
        n_pos        = pos_inc;
        n_start      = r_start;
        n_word       = r_word;
        n_len        = r_len;
        close_put    = 1'b0;
        close_kind   = open_kind;
        close_end    = r_pos;
        second_put   = 1'b0;
        second_kind  = f_kind;
        second_start = r_pos;
        second_end   = pos_inc;
        use_fresh    = 1'b0;

        if (i_command == CMD_END) begin
            // Flush the open token, then the end-of-file word; comments just vanish.
            close_put    = (r_mode != MODE_IDLE) && (r_mode != MODE_COMMENT);
            close_kind   = (r_mode == MODE_STRING) ? K_UNTERMINATED : open_kind;
            second_put   = 1'b1;
            second_kind  = K_EOF;
            second_end   = r_pos;
            n_mode       = MODE_IDLE;
            n_pend       = '0;
            n_line       = LINE_BITS'(1);
            n_pos        = '0;
            n_start      = '0;
            n_word       = '0;
            n_len        = '0;
        end else begin
            unique case (r_mode)
                MODE_IDLE: use_fresh = 1'b1;
                MODE_OP: begin
                    n_pend = '0;
                    n_mode = MODE_IDLE;
                    if (c == CH_EQUAL) begin
                        close_put  = 1'b1;
                        close_kind = op_kind(r_pend, 1'b1);
                        close_end  = pos_inc;
                    end else begin
                        close_put = 1'b1;
                        use_fresh = 1'b1;
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        n_mode = MODE_COMMENT;
                    end else begin
                        close_put = 1'b1;
                        use_fresh = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_NL) begin
                        use_fresh = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (!is_digit(c)) begin
                        close_put = 1'b1;
                        use_fresh = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (is_word(c) || is_digit(c)) begin
                        if (r_len < LEN_BITS'(KEYWORD_CHARS)) begin
                            n_word = {r_word[WORD_BITS-9:0], c};
                            n_len  = r_len + 1'b1;
                        end else begin
                            n_len = LEN_BITS'(KEYWORD_CHARS + 1);
                        end
                    end else begin
                        close_put = 1'b1;
                        use_fresh = 1'b1;
                        n_word    = '0;
                        n_len     = '0;
                    end
                end
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        close_put  = 1'b1;
                        close_kind = K_STRING;
                        close_end  = pos_inc;
                        n_mode     = MODE_IDLE;
                    end else if (c == CH_NL) begin
                        n_line = line_inc;
                    end
                end
                default: begin
                    n_mode    = MODE_IDLE;
                    use_fresh = 1'b1;
                end
            endcase

            if (use_fresh) begin
                n_mode     = f_mode;
                second_put = f_put;
                // A newline that closes a token counts after that token is given.
                if (f_nl) begin
                    n_line = line_inc;
                end
                if (f_open) begin
                    n_start = r_pos;
                end
                if (f_pend) begin
                    n_pend = c;
                end
                if (f_ident) begin
                    n_word = WORD_BITS'(c);
                    n_len  = LEN_BITS'(1);
                end
            end
        end
    end

    // Every result of one word carries the line count held before that word.
    always_comb begin
        res_close.kind   = close_kind;
        res_close.line   = r_line;
        res_close.start  = r_start;
        res_close.stop   = close_end;
        res_close.last   = !second_put;

        res_second.kind  = second_kind;
        res_second.line  = r_line;
        res_second.start = second_start;
        res_second.stop  = second_end;
        res_second.last  = 1'b1;

        if (close_put) begin
            data0      = res_close;
            data1      = res_second;
            push.push0 = accept;
            push.push1 = accept && second_put;
        end else begin
            data0      = res_second;
            data1      = res_second;
            push.push0 = accept && second_put;
            push.push1 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pend  <= '0;
            r_line  <= LINE_BITS'(1);
            r_pos   <= '0;
            r_start <= '0;
            r_word  <= '0;
            r_len   <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_line  <= n_line;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_word  <= n_word;
            r_len   <= n_len;
        end
    end

    sts_out_fifo #(
        .WIDTH($bits(t_result))
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data0 (data0),
        .i_data1 (data1),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_word)
    );

    assign o_token_kind   = out_word.kind;
    assign o_token_line   = out_word.line;
    assign o_start_offset = out_word.start;
    assign o_end_offset   = out_word.stop;
    assign o_last_of_run  = out_word.last;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the source token scanner: directed table, then random source text.
module tb;
    import sts_pkg::*;

    localparam int POS_W        = 24;
    localparam int LINE_W       = 20;
    localparam int KW_CHARS     = 6;
    localparam int WORD_GOAL    = 1250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ODDS_IDLE    = 29;
    localparam int CALM_FROM    = 500;
    localparam int CALM_TO      = 720;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 40;

    // Kinds the package does not name, and a filler for table rows that are not typed in.
    localparam t_kind KIND_BANG_EQUAL = K_BANG + 6'd1;
    localparam t_kind UNCHECKED       = '0;

    // The sixteen reserved words, right-aligned with the first character most significant.
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [16] = '{
        "and", "class", "else", "false", "fun", "for", "if", "nil",
        "or", "print", "return", "super", "this", "true", "var", "while"
    };

    localparam logic [7:0] OP_CHARS [4] = '{CH_BANG, CH_EQUAL, CH_LESS, CH_GREATER};
    localparam logic [7:0] PUNCT_CHARS [11] = '{
        CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA, CH_DOT,
        CH_MINUS, CH_PLUS, CH_SEMI, CH_STAR, CH_SLASH
    };
    localparam logic [7:0] GAP_CHARS [7] = '{
        CH_SPACE, CH_SPACE, CH_SPACE, CH_TAB, CH_CR, CH_NL, CH_NL
    };

    // One token as it leaves the block.
    typedef struct packed {
        t_kind             kind;
        logic [LINE_W-1:0] line;
        logic [POS_W-1:0]  first;
        logic [POS_W-1:0]  past;
        logic              last;
    } t_token;

    // One input word; where typed is set, the first token it causes is given by hand.
    typedef struct packed {
        logic              cmd;
        logic [7:0]        ch;
        logic              typed;
        t_kind             kind;
        logic [LINE_W-1:0] line;
        logic [POS_W-1:0]  first;
        logic [POS_W-1:0]  past;
    } t_row;

    // Directed table. It walks the operators != and >, a two-line string, a number closed by a dot,
    // a comment, a keyword, bytes that are not part of the language (NUL and 0xFF), the end
    // of source with an open slash, an unterminated string and an empty source.
    localparam int SCRIPT_LEN = 23;
    localparam t_row SCRIPT [SCRIPT_LEN] = '{
        '{CMD_BYTE, CH_LPAREN,  1'b1, K_LEFT_PAREN,    20'd1, 24'd0,  24'd1},
        '{CMD_BYTE, 8'h00,      1'b1, K_UNEXPECTED,    20'd1, 24'd1,  24'd2},
        '{CMD_BYTE, 8'hFF,      1'b1, K_UNEXPECTED,    20'd1, 24'd2,  24'd3},
        '{CMD_BYTE, CH_BANG,    1'b0, UNCHECKED,       20'd0, 24'd0,  24'd0},
        '{CMD_BYTE, CH_EQUAL,   1'b1, KIND_BANG_EQUAL, 20'd1, 24'd3,  24'd5},
        '{CMD_BYTE, CH_GREATER, 1'b0, UNCHECKED,       20'd0, 24'd0,  24'd0},
        '{CMD_BYTE, CH_SEMI,    1'b0, UNCHECKED,       20'd0, 24'd0,  24'd0},
        '{CMD_BYTE, CH_QUOTE,   1'b0, UNCHECKED,       20'd0, 24'd0,  24'd0},
        '{CMD_BYTE, CH_NL,      1'b0, UNCHECKED,       20'd0, 24'd0,  24'd0},
        '{CMD_BYTE, CH_QUOTE,   1'b1, K_STRING,        20'd2, 24'd7,  24'd10},
        '{CMD_BYTE, "9",        1'b0, UNCHECKED,       20'd0, 24'd0,  24'd0},
        '{CMD_BYTE, CH_DOT,     1'b0, UNCHECKED,       20'd0, 24'd0,  24'd0},
        '{CMD_BYTE, CH_SLASH,   1'b0, UNCHECKED,       20'd0, 24'd0,  24'd0},
        '{CMD_BYTE, CH_SLASH,   1'b0, UNCHECKED,       20'd0, 24'd0,  24'd0},
        '{CMD_BYTE, CH_NL,      1'b0, UNCHECKED,       20'd0, 24'd0,  24'd0},
        '{CMD_BYTE, "o",        1'b0, UNCHECKED,       20'd0, 24'd0,  24'd0},
        '{CMD_BYTE, "r",        1'b0, UNCHECKED,       20'd0, 24'd0,  24'd0},
        '{CMD_BYTE, CH_TAB,     1'b0, UNCHECKED,       20'd0, 24'd0,  24'd0},
        '{CMD_BYTE, CH_SLASH,   1'b0, UNCHECKED,       20'd0, 24'd0,  24'd0},
        '{CMD_END,  8'hA5,      1'b1, K_SLASH,         20'd3, 24'd18, 24'd19},
        '{CMD_BYTE, CH_QUOTE,   1'b0, UNCHECKED,       20'd0, 24'd0,  24'd0},
        '{CMD_END,  8'h00,      1'b1, K_UNTERMINATED,  20'd1, 24'd0,  24'd1},
        '{CMD_END,  8'h5A,      1'b1, K_EOF,           20'd1, 24'd0,  24'd0}
    };

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_command = CMD_BYTE;
    logic [7:0]        in_byte    = 8'h00;
    logic              out_ready  = 1'b0;
    logic              in_ready;
    logic              out_valid;
    t_kind             out_kind;
    logic [LINE_W-1:0] out_line;
    logic [POS_W-1:0]  out_first;
    logic [POS_W-1:0]  out_past;
    logic              out_last;

    // While calm is set neither side idles, which gives one long back-to-back stretch.
    bit     calm        = 1'b0;
    int     words_sent  = 0;
    int     words_seen  = 0;
    int     faults      = 0;
    longint cycles      = 0;

    t_token     tokens_due [$];
    t_token     step_tokens [$];
    logic [7:0] src_bytes [$];

    // Scanner state as the predictor keeps it.
    t_mode                    scan_mode;
    logic [7:0]               held_op;
    logic [LINE_W-1:0]        line_no;
    logic [POS_W-1:0]         next_pos;
    logic [POS_W-1:0]         tok_start;
    logic [8*KW_CHARS-1:0]    word_bits;
    logic [2:0]               word_len;

    source_token_scanner_core #(
        .POS_BITS      (POS_W),
        .LINE_BITS     (LINE_W),
        .KEYWORD_CHARS (KW_CHARS)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_command      (in_command),
        .i_source_byte  (in_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_token_kind   (out_kind),
        .o_token_line   (out_line),
        .o_start_offset (out_first),
        .o_end_offset   (out_past),
        .o_last_of_run  (out_last)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [POS_W-1:0] pos_after(input logic [POS_W-1:0] p);
        return (&p) ? p : p + 1'b1;
    endfunction

    function automatic logic [LINE_W-1:0] line_after(input logic [LINE_W-1:0] n);
        return (&n) ? n : n + 1'b1;
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic name_start_char(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_UNDER);
    endfunction

    function automatic void clear_scan();
        scan_mode = MODE_IDLE;
        held_op   = '0;
        line_no   = LINE_W'(1);
        next_pos  = '0;
        tok_start = '0;
        word_bits = '0;
        word_len  = '0;
    endfunction

    function automatic void emit(input t_kind k, input logic [POS_W-1:0] s,
                                 input logic [POS_W-1:0] e);
        t_token t;
        t.kind  = k;
        t.line  = line_no;
        t.first = s;
        t.past  = e;
        t.last  = 1'b0;
        step_tokens.insert(step_tokens.size(), t);
    endfunction

    // Appends one byte to the source text being built.
    function automatic void add_byte(input logic [7:0] v);
        src_bytes.insert(src_bytes.size(), v);
    endfunction

    // Comparison operators: the two-character form is always the next kind up.
    function automatic t_kind op_code(input logic [7:0] ch, input logic two);
        t_kind base;
        case (ch)
            CH_BANG:    base = K_BANG;
            CH_EQUAL:   base = K_EQUAL;
            CH_GREATER: base = K_GREATER;
            default:    base = K_LESS;
        endcase
        return base + t_kind'(two);
    endfunction

    // A word longer than the held characters can never be reserved.
    function automatic t_kind word_kind();
        int n;
        if (word_len > KW_CHARS) return K_IDENT;
        for (int i = 0; i < 16; i++) begin
            n = 0;
            for (int j = 0; j < KW_CHARS; j++) begin
                if (KW_TEXT[i][8*j +: 8] != 8'd0) n++;
            end
            if (n == word_len && KW_TEXT[i] == word_bits) return K_KEYWORD0 + t_kind'(i);
        end
        return K_IDENT;
    endfunction

    // A byte seen with no token open.
    function automatic void scan_new(input logic [7:0] c, input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] nxt;
        nxt = pos_after(pos);
        case (c)
            CH_SPACE, CH_CR, CH_TAB: ;
            CH_NL:     line_no = line_after(line_no);
            CH_LPAREN: emit(K_LEFT_PAREN, pos, nxt);
            CH_RPAREN: emit(K_RIGHT_PAREN, pos, nxt);
            CH_LBRACE: emit(K_LEFT_BRACE, pos, nxt);
            CH_RBRACE: emit(K_RIGHT_BRACE, pos, nxt);
            CH_COMMA:  emit(K_COMMA, pos, nxt);
            CH_DOT:    emit(K_DOT, pos, nxt);
            CH_MINUS:  emit(K_MINUS, pos, nxt);
            CH_PLUS:   emit(K_PLUS, pos, nxt);
            CH_SEMI:   emit(K_SEMICOLON, pos, nxt);
            CH_STAR:   emit(K_STAR, pos, nxt);
            CH_BANG, CH_EQUAL, CH_LESS, CH_GREATER: begin
                scan_mode = MODE_OP;
                held_op   = c;
                tok_start = pos;
            end
            CH_SLASH: begin
                scan_mode = MODE_SLASH;
                tok_start = pos;
            end
            CH_QUOTE: begin
                scan_mode = MODE_STRING;
                tok_start = pos;
            end
            default: begin
                if (digit_char(c)) begin
                    scan_mode = MODE_NUMBER;
                    tok_start = pos;
                end else if (name_start_char(c)) begin
                    scan_mode = MODE_IDENT;
                    tok_start = pos;
                    word_bits = {{(8*KW_CHARS-8){1'b0}}, c};
                    word_len  = 3'd1;
                end else begin
                    emit(K_UNEXPECTED, pos, nxt);
                end
            end
        endcase
    endfunction

    // Works out the tokens that one accepted input word causes, into step_tokens.
    function automatic void predict_word(input logic cmd, input logic [7:0] c);
        logic [POS_W-1:0] pos;
        t_token           t;
        pos = next_pos;
        step_tokens.delete();
        if (cmd == CMD_END) begin
            // The open token is closed at the current offset; a comment gives nothing.
            case (scan_mode)
                MODE_STRING: emit(K_UNTERMINATED, tok_start, pos);
                MODE_OP:     emit(op_code(held_op, 1'b0), tok_start, pos);
                MODE_SLASH:  emit(K_SLASH, tok_start, pos);
                MODE_NUMBER: emit(K_NUMBER, tok_start, pos);
                MODE_IDENT:  emit(word_kind(), tok_start, pos);
                default: ;
            endcase
            emit(K_EOF, pos, pos);
            clear_scan();
        end else begin
            case (scan_mode)
                MODE_IDLE: scan_new(c, pos);
                MODE_OP: begin
                    if (c == CH_EQUAL) begin
                        emit(op_code(held_op, 1'b1), tok_start, pos_after(pos));
                        scan_mode = MODE_IDLE;
                        held_op   = '0;
                    end else begin
                        emit(op_code(held_op, 1'b0), tok_start, pos);
                        scan_mode = MODE_IDLE;
                        held_op   = '0;
                        scan_new(c, pos);
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        scan_mode = MODE_COMMENT;
                    end else begin
                        emit(K_SLASH, tok_start, pos);
                        scan_mode = MODE_IDLE;
                        scan_new(c, pos);
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_NL) begin
                        scan_mode = MODE_IDLE;
                        scan_new(c, pos);
                    end
                end
                MODE_NUMBER: begin
                    if (!digit_char(c)) begin
                        emit(K_NUMBER, tok_start, pos);
                        scan_mode = MODE_IDLE;
                        scan_new(c, pos);
                    end
                end
                MODE_IDENT: begin
                    if (name_start_char(c) || digit_char(c)) begin
                        if (word_len < KW_CHARS) begin
                            word_bits = {word_bits[8*KW_CHARS-9:0], c};
                            word_len  = word_len + 3'd1;
                        end else begin
                            word_len = 3'(KW_CHARS + 1);
                        end
                    end else begin
                        emit(word_kind(), tok_start, pos);
                        scan_mode = MODE_IDLE;
                        word_bits = '0;
                        word_len  = '0;
                        scan_new(c, pos);
                    end
                end
                MODE_STRING: begin
                    // Newlines inside a string count, so the token carries the closing line.
                    if (c == CH_QUOTE) begin
                        emit(K_STRING, tok_start, pos_after(pos));
                        scan_mode = MODE_IDLE;
                    end else if (c == CH_NL) begin
                        line_no = line_after(line_no);
                    end
                end
                default: begin
                    scan_mode = MODE_IDLE;
                    scan_new(c, pos);
                end
            endcase
            next_pos = pos_after(next_pos);
        end
        if (step_tokens.size() > 0) begin
            t = step_tokens[step_tokens.size()-1];
            t.last = 1'b1;
            step_tokens[step_tokens.size()-1] = t;
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [7:0] name_char(input logic lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26) return 8'h61 + 8'(r);
        if (r < 52) return 8'h41 + 8'(r - 26);
        if (r == 52) return CH_UNDER;
        return 8'h30 + 8'(r - 53);
    endfunction

    // Builds one source text in src_bytes: mostly well-formed tokens with random
    // separators (often none, so one byte closes one token and opens the next),
    // mixed with raw bytes; the last string or comment is sometimes left open.
    task automatic build_source();
        int         pieces;
        int         r;
        int         n;
        int         pick;
        logic       closing;
        logic [7:0] b;
        src_bytes.delete();
        pieces = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(3, 24);
        for (int p = 0; p < pieces; p++) begin
            closing = (p != pieces - 1) || ($urandom_range(0, 2) != 0);
            r = $urandom_range(0, 99);
            if (r < 12) begin
                // A reserved word, sometimes with one more character so it is not one.
                pick = $urandom_range(0, 15);
                for (int j = KW_CHARS - 1; j >= 0; j--) begin
                    if (KW_TEXT[pick][8*j +: 8] != 8'd0) add_byte(KW_TEXT[pick][8*j +: 8]);
                end
                if ($urandom_range(0, 3) == 0) add_byte(name_char(1'b0));
            end else if (r < 28) begin
                n = $urandom_range(1, 9);
                add_byte(name_char(1'b1));
                for (int j = 1; j < n; j++) add_byte(name_char(1'b0));
            end else if (r < 38) begin
                n = $urandom_range(1, 4);
                for (int j = 0; j < n; j++) add_byte(8'h30 + 8'($urandom_range(0, 9)));
            end else if (r < 52) begin
                add_byte(OP_CHARS[$urandom_range(0, 3)]);
                if ($urandom_range(0, 1) == 0) add_byte(CH_EQUAL);
            end else if (r < 66 || r >= 88) begin
                add_byte(PUNCT_CHARS[$urandom_range(0, 10)]);
            end else if (r < 74) begin
                add_byte(CH_QUOTE);
                n = $urandom_range(0, 6);
                for (int j = 0; j < n; j++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        add_byte(CH_NL);
                    end else begin
                        b = 8'($urandom_range(32, 126));
                        add_byte((b == CH_QUOTE) ? CH_SPACE : b);
                    end
                end
                if (closing) add_byte(CH_QUOTE);
            end else if (r < 80) begin
                add_byte(CH_SLASH);
                add_byte(CH_SLASH);
                n = $urandom_range(0, 5);
                for (int j = 0; j < n; j++) begin
                    b = 8'($urandom_range(0, 255));
                    add_byte((b == CH_NL) ? CH_STAR : b);
                end
                if (closing) add_byte(CH_NL);
            end else begin
                add_byte(8'($urandom_range(0, 255)));
            end
            r = $urandom_range(0, 9);
            if (r >= 3) add_byte(GAP_CHARS[r-3]);
        end
    endtask

    // Offers one word, waits for it to be taken, then queues the tokens it causes.
    // Valid is only lowered in a gap, so a word that follows directly keeps it high.
    task automatic feed(input t_row row);
        t_token t;
        while (!calm && $urandom_range(0, 99) < ODDS_IDLE) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_command <= row.cmd;
        in_byte    <= row.ch;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_word(row.cmd, row.ch);
        if (row.typed && step_tokens.size() > 0) begin
            t       = step_tokens[0];
            t.kind  = row.kind;
            t.line  = row.line;
            t.first = row.first;
            t.past  = row.past;
            step_tokens[0] = t;
        end
        foreach (step_tokens[k]) tokens_due.insert(tokens_due.size(), step_tokens[k]);
        words_sent++;
        calm = (words_sent >= CALM_FROM) && (words_sent < CALM_TO);
    endtask

    task automatic report_mismatch(input string msg);
        faults++;
        if (faults <= PRINT_CAP) $display("MISMATCH %s", msg);
    endtask

    // ---------------------------------------------------------------- main sequence

    initial begin
        t_row item;
        clear_scan();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++) feed(SCRIPT[i]);

        while (words_sent < WORD_GOAL) begin
            build_source();
            foreach (src_bytes[k]) begin
                item = '{CMD_BYTE, src_bytes[k], 1'b0, UNCHECKED, '0, '0, '0};
                feed(item);
            end
            item = '{CMD_END, 8'($urandom_range(0, 255)), 1'b0, UNCHECKED, '0, '0, '0};
            feed(item);
        end
        in_valid <= 1'b0;

        // Drain, then keep watching for tokens nobody asked for.
        while (tokens_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (faults == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // ---------------------------------------------------------------- result check

    // Outputs are sampled at the clock edge before the block updates them; each accepted
    // word is compared field by field with the oldest expected token.
    initial begin
        t_token want;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                words_seen++;
                if (tokens_due.size() == 0) begin
                    report_mismatch($sformatf("word %0d: no token expected, got kind %0d",
                                              words_seen, out_kind));
                end else begin
                    want = tokens_due.pop_front();
                    if (out_kind !== want.kind)
                        report_mismatch($sformatf("word %0d kind: expected %0d, got %0d",
                                                  words_seen, want.kind, out_kind));
                    if (out_line !== want.line)
                        report_mismatch($sformatf("word %0d line: expected %0d, got %0d",
                                                  words_seen, want.line, out_line));
                    if (out_first !== want.first)
                        report_mismatch($sformatf("word %0d start: expected %0d, got %0d",
                                                  words_seen, want.first, out_first));
                    if (out_past !== want.past)
                        report_mismatch($sformatf("word %0d end: expected %0d, got %0d",
                                                  words_seen, want.past, out_past));
                    if (out_last !== want.last)
                        report_mismatch($sformatf("word %0d last: expected %0d, got %0d",
                                                  words_seen, want.last, out_last));
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= ODDS_IDLE);
        end
    end

    // Ends a run that hangs, far beyond the slowest correct run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
hw/rtl/sts_pkg.sv
hw/rtl/sts_out_fifo.sv
hw/rtl/source_token_scanner_core.sv
tb/sv/tb.sv
